[rtl/mbfd_pkg.sv]
package mbfd_pkg;

    localparam int CFG_W             = 11;
    localparam int CFG_IDX_W         = 1;
    localparam int MAX_LEVEL_WIDTH_D = 1024;
    localparam int HEIGHT_LIMIT      = 1024;
    localparam int ROW_W             = 10;
    localparam int CHAN_N            = 4;
    localparam int CHAN_W            = 8;
    localparam int PSUM_W            = CHAN_W + 1;
    localparam int TOT_W             = CHAN_W + 2;
    localparam int PIX_W             = CHAN_N * CHAN_W;
    localparam int LINE_W            = CHAN_N * PSUM_W;

    localparam logic [CFG_W-1:0] LEVEL_WIDTH_RST  = CFG_W'(256);
    localparam logic [CFG_W-1:0] LEVEL_HEIGHT_RST = CFG_W'(256);

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;

    localparam cfg_idx_t REG_LEVEL_WIDTH  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_LEVEL_HEIGHT = cfg_idx_t'(1);

    typedef logic [CHAN_N-1:0][CHAN_W-1:0] pixel_t;
    typedef logic [CHAN_N-1:0][PSUM_W-1:0] psum_t;

    // Result waiting on the line store read.
    typedef struct packed {
        psum_t psum;
        logic  done;
    } pend_t;

endpackage

[rtl/mbfd_ram.sv]
module mbfd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 512
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mipmap_box_filter_downsampler.sv]
// 2x2 box-filter mipmap downsampler. Pixels of four 8-bit channels enter in
// raster order, one beat per pixel, and each 2x2 block leaves as one pixel
// holding the truncated average (four-pixel sum shifted right by two) of each
// channel. Even rows store their horizontal pair sums in a single-port line
// store of MAX_LEVEL_WIDTH/2 entries; on the second pixel of each pair in an
// odd row the store is read; the result passes the pending stage and the
// output register. The block takes one pixel per cycle while the output side
// keeps up: the single line store port sees at most one access per input beat
// (a write on even rows, a read on odd rows), so nothing limits the rate below
// one beat per cycle. A result waiting in the output register does not stop input;
// only a pending read whose result cannot move on holds s_tready low.
// s_tuser marks the first pixel of an image and resets the position; without
// it, the position wraps to the image origin after the last pixel. An odd
// trailing row is consumed without output, m_tlast marks the last pixel of
// the reduced level. Write level_width and level_height on the cfg port only
// while the block is idle; the width's low bit is ignored.
module mipmap_box_filter_downsampler #(
    parameter int MAX_LEVEL_WIDTH = mbfd_pkg::MAX_LEVEL_WIDTH_D
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  mbfd_pkg::cfg_idx_t      cfg_index,
    input  mbfd_pkg::cfg_data_t     cfg_data,
    // pixel input
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [31:0]             s_tdata,   // chan0_in, chan1_in, chan2_in, chan3_in
    input  logic                    s_tuser,   // start_of_image
    // reduced pixel output
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,   // chan0_out, chan1_out, chan2_out, chan3_out
    output logic                    m_tlast    // level_done
);

    import mbfd_pkg::*;

    localparam int COL_W     = (MAX_LEVEL_WIDTH > 2) ? $clog2(MAX_LEVEL_WIDTH) : 1;
    localparam int WW_RAW    = $clog2(MAX_LEVEL_WIDTH) + 1;
    localparam int WW        = (WW_RAW > CFG_W) ? WW_RAW : CFG_W;
    localparam int DEPTH     = MAX_LEVEL_WIDTH / 2;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAX_EVEN  = MAX_LEVEL_WIDTH - (MAX_LEVEL_WIDTH % 2);
    localparam int HW        = CFG_W;

    // configuration registers
    logic [CFG_W-1:0] level_width_reg, level_width_next;
    logic [CFG_W-1:0] level_height_reg, level_height_next;

    // position and pair state
    logic [COL_W-1:0] column_pos_reg, column_pos_next;
    logic [ROW_W-1:0] row_pos_reg, row_pos_next;
    pixel_t           left_pixel_reg, left_pixel_next;

    // read-pending stage and output register
    logic             pend_vld_reg, pend_vld_next;
    pend_t            pend_reg, pend_next;
    logic             out_vld_reg, out_vld_next;
    pixel_t           out_pix_reg, out_pix_next;
    logic             out_last_reg, out_last_next;

    logic             s_fire;
    logic             adv;
    logic [WW-1:0]    lw_even;
    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic [HW-1:0]    last_out_row;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             row_end;
    logic             col_odd;
    logic             row_odd;
    logic             produce;
    pixel_t           pix;
    psum_t            pair_sum;
    psum_t            stored;
    logic [TOT_W-1:0] tot;
    logic             ram_en;
    logic             ram_we;
    logic             ram_rd;
    logic [IDX_W-1:0] ram_addr;
    logic [LINE_W-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    // the output register frees up this cycle
    assign adv      = !out_vld_reg || m_tready;
    // a pending read may always move into a free output register
    assign s_tready = !pend_vld_reg || adv;
    assign s_fire   = s_tvalid && s_tready;

    // effective geometry: clamp to the supported range
    always_comb
    begin
        lw_even = WW'(level_width_reg) & ~WW'(1);
        if (lw_even < WW'(2))
        begin
            eff_w = WW'(2);
        end
        else if (lw_even > WW'(MAX_LEVEL_WIDTH))
        begin
            eff_w = WW'(MAX_EVEN);
        end
        else
        begin
            eff_w = lw_even;
        end

        if (level_height_reg < HW'(2))
        begin
            eff_h = HW'(2);
        end
        else if (level_height_reg > HW'(HEIGHT_LIMIT))
        begin
            eff_h = HW'(HEIGHT_LIMIT);
        end
        else
        begin
            eff_h = level_height_reg;
        end
        last_out_row = (eff_h & ~HW'(1)) - HW'(1);
    end

    assign pix     = pixel_t'(s_tdata);
    assign col     = s_tuser ? '0 : column_pos_reg;
    assign row     = s_tuser ? '0 : row_pos_reg;
    assign row_end = (WW'(col) + WW'(1)) >= eff_w;
    assign col_odd = col[0];
    assign row_odd = row[0];
    assign produce = col_odd && row_odd && (HW'(row) <= last_out_row);

    always_comb
    begin
        for (int c = 0; c < CHAN_N; c++)
        begin
            pair_sum[c] = PSUM_W'(left_pixel_reg[c]) + PSUM_W'(pix[c]);
        end
    end

    // line store access: write pair sums on even rows, read them on odd rows
    assign ram_we   = s_fire && col_odd && !row_odd;
    assign ram_rd   = s_fire && produce;
    assign ram_en   = ram_we || ram_rd;
    assign ram_addr = IDX_W'(col >> 1);

    mbfd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (DEPTH)
    ) u_line (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (LINE_W'(pair_sum)),
        .rdata (ram_rdata)
    );

    assign stored = psum_t'(ram_rdata);

    always_comb
    begin
        level_width_next  = level_width_reg;
        level_height_next = level_height_reg;
        column_pos_next   = column_pos_reg;
        row_pos_next      = row_pos_reg;
        left_pixel_next   = left_pixel_reg;
        pend_vld_next     = pend_vld_reg;
        pend_next         = pend_reg;
        out_vld_next      = out_vld_reg;
        out_pix_next      = out_pix_reg;
        out_last_next     = out_last_reg;
        tot               = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEVEL_WIDTH:  level_width_next  = cfg_data;
                REG_LEVEL_HEIGHT: level_height_next = cfg_data;
                default: ;
            endcase
        end

        // drain the pending result into the output register
        if (adv)
        begin
            out_vld_next = pend_vld_reg;
            if (pend_vld_reg)
            begin
                for (int c = 0; c < CHAN_N; c++)
                begin
                    tot             = TOT_W'(stored[c]) + TOT_W'(pend_reg.psum[c]);
                    out_pix_next[c] = tot[TOT_W-1:2];
                end
                out_last_next = pend_reg.done;
            end
            pend_vld_next = 1'b0;
        end

        if (s_fire)
        begin
            if (!col_odd)
            begin
                left_pixel_next = pix;
            end
            if (produce)
            begin
                pend_vld_next  = 1'b1;
                pend_next.psum = pair_sum;
                pend_next.done = row_end && (HW'(row) == last_out_row);
            end
            // advance the position, wrapping at row and image end
            if (row_end)
            begin
                column_pos_next = '0;
                if ((HW'(row) + HW'(1)) >= eff_h)
                begin
                    row_pos_next = '0;
                end
                else
                begin
                    row_pos_next = row + ROW_W'(1);
                end
            end
            else
            begin
                column_pos_next = col + COL_W'(1);
                row_pos_next    = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_width_reg  <= LEVEL_WIDTH_RST;
            level_height_reg <= LEVEL_HEIGHT_RST;
            column_pos_reg   <= '0;
            row_pos_reg      <= '0;
            left_pixel_reg   <= '0;
            pend_vld_reg     <= 1'b0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            level_width_reg  <= level_width_next;
            level_height_reg <= level_height_next;
            column_pos_reg   <= column_pos_next;
            row_pos_reg      <= row_pos_next;
            left_pixel_reg   <= left_pixel_next;
            pend_vld_reg     <= pend_vld_next;
            out_vld_reg      <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_pix_reg  <= out_pix_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = 32'(out_pix_reg);
    assign m_tlast  = out_last_reg;

    // a pending result always has its line store read issued the cycle before
    a_pend_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_vld_reg) |-> $past(ram_rd))
        else $error("pending result without line store read");

    // a read is issued only when a pending slot is available
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd |=> pend_vld_reg)
        else $error("line store read lost");

    // a stalled pending result keeps its partial sum and the read data
    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_vld_reg && !adv) |=> (pend_vld_reg && $stable(pend_reg)
                                    && $stable(ram_rdata)))
        else $error("stalled pending result changed");

    // the line store is never written and read in the same cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_rd))
        else $error("line store port conflict");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mbfd_pkg::*;

    localparam int STALL_LIMIT  = 2000;   // cycles with no beat on any channel
    localparam int HOLD_CYCLES  = 200;    // long output hold-off
    localparam int HOLD_AT      = 1100;   // pixel count that starts the hold-off
    localparam int CALM_FROM    = 1200;   // output side never idles in this pixel window
    localparam int CALM_TO      = 1400;
    localparam int SETTLE_WAIT  = 8;      // result passes the pending and output registers after its input beat
    localparam int SMALL_ITEMS  = 300;
    localparam int WIDE_ITEMS   = MAX_LEVEL_WIDTH_D + 128;
    localparam int DIRECTED_N   = 26;

    typedef enum logic [0:0] {STEP_PIXEL, STEP_REG} step_kind_t;

    typedef struct packed {
        pixel_t avg;
        logic   done;
    } block_avg_t;

    // One row of the directed table. Rows with typed set carry their own
    // expectation; all other rows are checked against the predictor.
    typedef struct packed {
        step_kind_t kind;
        logic       sof;
        pixel_t     px;
        bit         typed;
        bit         emits;
        block_avg_t want;
        cfg_idx_t   reg_idx;
        cfg_data_t  reg_val;
    } dir_step_t;

    localparam dir_step_t DIRECTED [DIRECTED_N] = '{
        // width 1 reads as 2, odd height 3: one full block, then a dropped row
        '{STEP_REG,   1'b0, '0,           1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  11'd1},
        '{STEP_REG,   1'b0, '0,           1'b0, 1'b0, '0, REG_LEVEL_HEIGHT, 11'd3},
        '{STEP_PIXEL, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1},
          REG_LEVEL_WIDTH, '0},
        '{STEP_PIXEL, 1'b0, 32'h1234_5678, 1'b1, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'h9ABC_DEF0, 1'b1, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        // second image follows with no start flag; a sum of 3 truncates to 0
        '{STEP_PIXEL, 1'b0, 32'h0000_0000, 1'b1, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'h0000_0000, 1'b1, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'h0000_0000, 1'b1, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'h0303_0303, 1'b1, 1'b1, '{32'h0000_0000, 1'b1},
          REG_LEVEL_WIDTH, '0},
        '{STEP_PIXEL, 1'b0, 32'hFF00_FF00, 1'b1, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'h00FF_00FF, 1'b1, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        // oversize width clamps, zero height reads as 2; restart mid-row
        '{STEP_REG,   1'b0, '0,           1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  11'd2047},
        '{STEP_REG,   1'b0, '0,           1'b0, 1'b0, '0, REG_LEVEL_HEIGHT, 11'd0},
        '{STEP_PIXEL, 1'b1, 32'h0102_0304, 1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'h8080_8080, 1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b1, 32'h0101_0101, 1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'h0202_0202, 1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        // shrink the width mid-row: the next pixel (an even column) ends the row
        '{STEP_REG,   1'b0, '0,           1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  11'd2},
        '{STEP_PIXEL, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'h0000_0000, 1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_PIXEL, 1'b0, 32'h0000_0000, 1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  '0},
        '{STEP_REG,   1'b0, '0,           1'b0, 1'b0, '0, REG_LEVEL_WIDTH,  11'd8},
        '{STEP_REG,   1'b0, '0,           1'b0, 1'b0, '0, REG_LEVEL_HEIGHT, 11'd1025}
    };

    localparam cfg_data_t WIDTH_EDGES  [5] = '{11'd0, 11'd1, 11'd1024, 11'd1025, 11'd2047};
    localparam cfg_data_t HEIGHT_EDGES [5] = '{11'd0, 11'd1, 11'd3, 11'd1024, 11'd2047};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = '0;
    cfg_data_t   cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // chan0_in, chan1_in, chan2_in, chan3_in
    logic        s_tuser   = 1'b0; // start_of_image
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // chan0_out, chan1_out, chan2_out, chan3_out
    logic        m_tlast;          // level_done

    // Predictor state
    psum_t       line_sums [MAX_LEVEL_WIDTH_D/2];
    pixel_t      left_px    = '0;
    int unsigned pred_col   = 0;
    int unsigned pred_row   = 0;
    cfg_data_t   width_reg  = LEVEL_WIDTH_RST;
    cfg_data_t   height_reg = LEVEL_HEIGHT_RST;

    block_avg_t  expected_avgs [$];

    int unsigned pixels_in    = 0;
    int unsigned results_out  = 0;
    int unsigned level_ends   = 0;
    int unsigned cfg_writes   = 0;
    int unsigned errors       = 0;
    int unsigned stall_cycles = 0;
    bit          sender_calm  = 1'b0;

    always #5 clk = ~clk;

    mipmap_box_filter_downsampler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    function automatic int unsigned eff_width(cfg_data_t v);
        int unsigned w = 32'(v) & 32'h7FE;
        if (w < 2) w = 2;
        if (w > MAX_LEVEL_WIDTH_D) w = MAX_LEVEL_WIDTH_D;
        return w;
    endfunction

    function automatic int unsigned eff_height(cfg_data_t v);
        int unsigned h = 32'(v);
        if (h < 2) h = 2;
        if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
        return h;
    endfunction

    // Advance the predictor by one accepted pixel and report the reduced
    // pixel it completes, if any.
    function automatic void downsample_pixel(input logic sof, input pixel_t px,
                                             output bit emits, output block_avg_t res);
        int unsigned w;
        int unsigned h;
        int unsigned last_row;
        int unsigned idx;
        bit row_end;
        logic [TOT_W-1:0] total;
        w = eff_width(width_reg);
        h = eff_height(height_reg);
        last_row = (h & ~32'd1) - 1;
        emits = 1'b0;
        res = '0;
        if (sof)
        begin
            pred_col = 0;
            pred_row = 0;
        end
        row_end = (pred_col + 1 >= w);
        idx = pred_col >> 1;
        if (pred_col % 2 == 0)
        begin
            left_px = px;
        end
        else if (pred_row % 2 == 0)
        begin
            for (int c = 0; c < CHAN_N; c++)
                line_sums[idx][c] = PSUM_W'(left_px[c]) + PSUM_W'(px[c]);
        end
        else if (pred_row <= last_row)
        begin
            for (int c = 0; c < CHAN_N; c++)
            begin
                total = TOT_W'(line_sums[idx][c]) + TOT_W'(left_px[c]) + TOT_W'(px[c]);
                res.avg[c] = total[TOT_W-1:2];
            end
            res.done = row_end && (pred_row == last_row);
            emits = 1'b1;
        end
        if (row_end)
        begin
            pred_col = 0;
            pred_row = (pred_row + 1 >= h) ? 0 : pred_row + 1;
        end
        else
        begin
            pred_col++;
        end
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        p = $urandom;
        // now and then force every channel to an end of its range
        if ($urandom_range(0, 9) == 0)
            for (int c = 0; c < CHAN_N; c++)
                p[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    // Offer one pixel beat, with random idle cycles ahead of it when the sender is
    // not calm, and record what it should produce once it is taken.
    task automatic send_pixel(input logic sof, input pixel_t px, input bit typed,
                              input bit t_emits, input block_avg_t t_res);
        bit emits;
        block_avg_t res;
        while (!sender_calm && $urandom_range(0, 99) < 23)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= sof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        downsample_pixel(sof, px, emits, res);
        if (typed)
        begin
            emits = t_emits;
            res   = t_res;
        end
        if (emits)
            expected_avgs.push_back(res);
        pixels_in++;
    endtask

    // Drop the input, wait for every outstanding result, then let the block
    // finish any pixel that produces nothing.
    task automatic drain_and_pause();
        s_tvalid <= 1'b0;
        while (expected_avgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_LEVEL_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Output side: random stalls, one long hold-off while the wide image is
    // streaming so the block backs up into its input, and a calm window.
    initial
    begin : output_side
        int unsigned rx_cycle;
        bit held;
        rx_cycle = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (!held && pixels_in >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (pixels_in >= CALM_FROM && pixels_in < CALM_TO)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= 23);
            end
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        block_avg_t want;
        logic [CHAN_N-1:0] bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_avgs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reduced pixel %h last %b", $time, m_tdata, m_tlast);
            end
            else
            begin
                want = expected_avgs.pop_front();
                for (int c = 0; c < CHAN_N; c++)
                    bad[c] = (m_tdata[c*CHAN_W +: CHAN_W] !== want.avg[c]);
                if (bad != '0)
                begin
                    errors++;
                    $display("%0t: channel mismatch (mask %b) expected %h actual %h",
                             $time, bad, want.avg, m_tdata);
                end
                if (m_tlast !== want.done)
                begin
                    errors++;
                    $display("%0t: level_done mismatch expected %b actual %b",
                             $time, want.done, m_tlast);
                end
                results_out++;
                if (want.done)
                    level_ends++;
            end
        end
    end

    // Watchdog: end the run if no channel moves a beat for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, expected_avgs.size());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned small_items;
        int unsigned n;
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        cfg_data_t nw;
        cfg_data_t nh;
        logic sof;
        small_items = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            if (DIRECTED[i].kind == STEP_REG)
            begin
                drain_and_pause();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            end
            else
            begin
                send_pixel(DIRECTED[i].sof, DIRECTED[i].px, DIRECTED[i].typed,
                           DIRECTED[i].emits, DIRECTED[i].want);
            end
        end

        // Full-width even row and the start of the odd row after it, no input
        // gaps: writes the last line store entry and carries the output hold-off.
        drain_and_pause();
        write_reg(REG_LEVEL_WIDTH, WIDTH_EDGES[$urandom_range(2, 4)]);
        write_reg(REG_LEVEL_HEIGHT, 11'd2047);
        sender_calm = 1'b1;
        for (int k = 0; k < WIDE_ITEMS; k++)
            send_pixel(k == 0, random_pixel(), 1'b0, 1'b0, '0);
        sender_calm = 1'b0;

        // Small images under changing sizes, mostly whole frames with a start
        // flag, with stray restarts and partial frames mixed in.
        while (small_items < SMALL_ITEMS)
        begin
            drain_and_pause();
            nw = ($urandom_range(0, 9) == 0) ? WIDTH_EDGES[$urandom_range(0, 4)]
                                              : cfg_data_t'($urandom_range(0, 16));
            nh = ($urandom_range(0, 9) == 0) ? HEIGHT_EDGES[$urandom_range(0, 4)]
                                              : cfg_data_t'($urandom_range(0, 9));
            // never widen inside an odd row: its tail would read pair sums
            // that no even row has stored
            if (pred_row % 2 == 1 && eff_width(nw) > eff_width(width_reg))
                nw = width_reg;
            pick = $urandom_range(1, 3);
            if (pick[0])
                write_reg(REG_LEVEL_WIDTH, nw);
            if (pick[1])
                write_reg(REG_LEVEL_HEIGHT, nh);
            w = eff_width(width_reg);
            h = eff_height(height_reg);
            if (w * h <= 200)
                n = w * h * $urandom_range(1, 3);
            else
                n = $urandom_range(10, 150);
            for (int k = 0; k < n; k++)
            begin
                if ((w * h <= 200) ? (k % (w * h) == 0) : (k == 0))
                    sof = ($urandom_range(0, 3) != 0);
                else
                    sof = ($urandom_range(0, 59) == 0);
                send_pixel(sof, random_pixel(), 1'b0, 1'b0, '0);
            end
            small_items += n;
        end

        drain_and_pause();
        $display("testbench: %0d pixel beats in, %0d reduced pixels checked, %0d level ends",
                 pixels_in, results_out, level_ends);
        $display("testbench: %0d register writes across full-width, clamped and small sizes",
                 cfg_writes);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/mbfd_pkg.sv
rtl/mbfd_ram.sv
rtl/mipmap_box_filter_downsampler.sv
tb/testbench.sv
